// ----- src/pal_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package pal_pkg;

    localparam int PAL_CAPACITY = 128;
    localparam int PAL_DATA_W   = 32;
    localparam int PAL_POS_W    = 8;
    localparam int PAL_CNT_W    = 8;

    typedef enum logic [1:0] {
        PAL_FN_INSERT = 2'd0,
        PAL_FN_APPEND = 2'd1,
        PAL_FN_DELETE = 2'd2,
        PAL_FN_READ   = 2'd3
    } pal_func_t;

    typedef enum logic [1:0] {
        PAL_ST_OK     = 2'd0,
        PAL_ST_FULL   = 2'd1,
        PAL_ST_BADPOS = 2'd2,
        PAL_ST_EMPTY  = 2'd3
    } pal_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UP_RD,
        ST_UP_WR,
        ST_WRITE_NEW,
        ST_DEL_CAP,
        ST_DN_RD,
        ST_DN_WR,
        ST_RD_CAP
    } pal_state_t;

    typedef struct packed {
        pal_func_t                     func;
        logic [PAL_POS_W-1:0]          pos;
        logic signed [PAL_DATA_W-1:0]  value;
    } pal_in_t;

    typedef struct packed {
        logic signed [PAL_DATA_W-1:0]  data_out;
        logic [PAL_CNT_W-1:0]          count_out;
        pal_status_t                   status;
    } pal_out_t;

endpackage

`default_nettype wire

// ----- src/pal_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pal_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- src/pal_seq.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pal_seq
    import pal_pkg::*;
#(
    parameter int CAPACITY = PAL_CAPACITY
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire pal_in_t                     req,
    output logic                             busy,
    output logic                             emit,
    output pal_out_t                         rsp,
    output logic                             ram_we,
    output logic [$clog2(CAPACITY)-1:0]      ram_waddr,
    output logic [PAL_DATA_W-1:0]            ram_wdata,
    output logic [$clog2(CAPACITY)-1:0]      ram_raddr,
    input  wire logic [PAL_DATA_W-1:0]       ram_rdata
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > PAL_POS_W) ? CW : PAL_POS_W;

    pal_state_t                    state_reg, state_next;
    logic [CW-1:0]                 count_reg, count_next;
    logic [CW-1:0]                 idx_reg, idx_next;
    logic [AW-1:0]                 p_reg, p_next;
    logic signed [PAL_DATA_W-1:0]  v_reg, v_next;
    logic [PAL_DATA_W-1:0]         word_reg, word_next;

    logic [XW-1:0] pos_x;
    logic [XW-1:0] cnt_x;
    logic          full;
    logic          empty;
    logic          ins_bad;
    logic          rd_bad;
    logic [CW-1:0] idx_dec;
    logic [CW-1:0] idx_inc;
    logic [CW-1:0] idx_inc2;
    logic [CW-1:0] p_inc;

    // The index counter with its adders and comparators steps both shift loops.
    assign pos_x    = XW'(req.pos);
    assign cnt_x    = XW'(count_reg);
    assign full     = (count_reg == CW'(CAPACITY));
    assign empty    = (count_reg == '0);
    assign ins_bad  = (pos_x > cnt_x);
    assign rd_bad   = (pos_x >= cnt_x);
    assign idx_dec  = idx_reg - CW'(1);
    assign idx_inc  = idx_reg + CW'(1);
    assign idx_inc2 = idx_reg + CW'(2);
    assign p_inc    = CW'(p_reg) + CW'(1);

    assign busy = (state_reg != ST_IDLE);

    always_comb
    begin : next_state_logic
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (req.func)
                        PAL_FN_INSERT:
                        begin
                            if (!full && !ins_bad)
                            begin
                                state_next = (pos_x == cnt_x) ? ST_WRITE_NEW : ST_UP_RD;
                            end
                        end
                        PAL_FN_APPEND:
                        begin
                            if (!full)
                            begin
                                state_next = ST_WRITE_NEW;
                            end
                        end
                        PAL_FN_DELETE:
                        begin
                            if (!empty && !rd_bad)
                            begin
                                state_next = ST_DEL_CAP;
                            end
                        end
                        PAL_FN_READ:
                        begin
                            if (!empty && !rd_bad)
                            begin
                                state_next = ST_RD_CAP;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_UP_RD:
            begin
                state_next = ST_UP_WR;
            end
            ST_UP_WR:
            begin
                state_next = (idx_dec == CW'(p_reg)) ? ST_WRITE_NEW : ST_UP_RD;
            end
            ST_WRITE_NEW:
            begin
                state_next = ST_IDLE;
            end
            ST_DEL_CAP:
            begin
                state_next = (p_inc < count_reg) ? ST_DN_RD : ST_IDLE;
            end
            ST_DN_RD:
            begin
                state_next = ST_DN_WR;
            end
            ST_DN_WR:
            begin
                state_next = (idx_inc2 < count_reg) ? ST_DN_RD : ST_IDLE;
            end
            ST_RD_CAP:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin : output_logic
        ram_we        = 1'b0;
        ram_waddr     = idx_reg[AW-1:0];
        ram_wdata     = ram_rdata;
        ram_raddr     = '0;
        idx_next      = idx_reg;
        p_next        = p_reg;
        v_next        = v_reg;
        word_next     = word_reg;
        count_next    = count_reg;
        emit          = 1'b0;
        rsp.data_out  = '0;
        rsp.count_out = PAL_CNT_W'(count_reg);
        rsp.status    = PAL_ST_OK;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    v_next = req.value;
                    case (req.func)
                        PAL_FN_INSERT:
                        begin
                            if (full)
                            begin
                                emit       = 1'b1;
                                rsp.status = PAL_ST_FULL;
                            end
                            else if (ins_bad)
                            begin
                                emit       = 1'b1;
                                rsp.status = PAL_ST_BADPOS;
                            end
                            else
                            begin
                                idx_next = count_reg;
                                p_next   = AW'(req.pos);
                            end
                        end
                        PAL_FN_APPEND:
                        begin
                            if (full)
                            begin
                                emit       = 1'b1;
                                rsp.status = PAL_ST_FULL;
                            end
                            else
                            begin
                                p_next = AW'(count_reg);
                            end
                        end
                        PAL_FN_DELETE, PAL_FN_READ:
                        begin
                            if (empty)
                            begin
                                emit       = 1'b1;
                                rsp.status = PAL_ST_EMPTY;
                            end
                            else if (rd_bad)
                            begin
                                emit       = 1'b1;
                                rsp.status = PAL_ST_BADPOS;
                            end
                            else
                            begin
                                p_next    = AW'(req.pos);
                                ram_raddr = AW'(req.pos);
                            end
                        end
                        default:
                        begin
                            emit = 1'b0;
                        end
                    endcase
                end
            end
            ST_UP_RD:
            begin
                ram_raddr = idx_dec[AW-1:0];
            end
            ST_UP_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg[AW-1:0];
                ram_wdata = ram_rdata;
                idx_next  = idx_dec;
            end
            ST_WRITE_NEW:
            begin
                ram_we        = 1'b1;
                ram_waddr     = p_reg;
                ram_wdata     = v_reg;
                count_next    = count_reg + CW'(1);
                emit          = 1'b1;
                rsp.count_out = PAL_CNT_W'(count_next);
            end
            ST_DEL_CAP:
            begin
                word_next = ram_rdata;
                idx_next  = CW'(p_reg);
                if (!(p_inc < count_reg))
                begin
                    count_next    = count_reg - CW'(1);
                    emit          = 1'b1;
                    rsp.data_out  = ram_rdata;
                    rsp.count_out = PAL_CNT_W'(count_next);
                end
            end
            ST_DN_RD:
            begin
                ram_raddr = idx_inc[AW-1:0];
            end
            ST_DN_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg[AW-1:0];
                ram_wdata = ram_rdata;
                idx_next  = idx_inc;
                if (!(idx_inc2 < count_reg))
                begin
                    count_next    = count_reg - CW'(1);
                    emit          = 1'b1;
                    rsp.data_out  = word_reg;
                    rsp.count_out = PAL_CNT_W'(count_next);
                end
            end
            ST_RD_CAP:
            begin
                emit         = 1'b1;
                rsp.data_out = ram_rdata;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        p_reg    <= p_next;
        v_reg    <= v_next;
        word_reg <= word_next;
    end

    // The entry count never passes the capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    // The list store is written only while a request is being worked on.
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg != ST_IDLE))
        else $error("list store written while idle");

    // A result given straight from idle is always a refusal.
    assert property (@(posedge clk) disable iff (!rst_n)
        (emit && (state_reg == ST_IDLE)) |-> (rsp.status != PAL_ST_OK))
        else $error("successful result without any work");

    // The count moves only on the edge that completes a request.
    assert property (@(posedge clk) disable iff (!rst_n)
        !emit |=> (count_reg == $past(count_reg)))
        else $error("count changed without a result");

endmodule

`default_nettype wire

// ----- src/positional_array_list_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Positional array list: an ordered list of signed 32-bit words kept in a
// single-port-write, single-port-read RAM of CAPACITY entries.
// A request beat (req: func, pos, value) is taken on a rising edge where start
// is high and busy is low. Each request gives exactly one result beat on rsp
// (data_out, count_out, status), marked by done for a single cycle; the
// receiver cannot stall, so it must take the beat in that cycle.
// Inserts and deletes move the later entries one by one through the RAM:
// each moved entry needs one read state and one write state, stepped by a
// single index counter. busy is high while the sequencer is out of idle,
// never for a refusal; a new request may be taken in the same cycle as done.
// Reset empties the list at once by clearing the entry count; the RAM
// contents are left alone and are never read before they are written.

module positional_array_list_unit
    import pal_pkg::*;
#(
    parameter int CAPACITY = PAL_CAPACITY
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    input  wire pal_in_t req,
    output logic         busy,
    output logic         done,
    output pal_out_t     rsp
);

    localparam int AW = $clog2(CAPACITY);

    logic                  seq_emit;
    pal_out_t              seq_rsp;
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [PAL_DATA_W-1:0] ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [PAL_DATA_W-1:0] ram_rdata;

    logic     done_reg;
    pal_out_t rsp_reg;

    // The sequencer holds the entry count and steps the shift loop.
    pal_seq #(
        .CAPACITY (CAPACITY)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req       (req),
        .busy      (busy),
        .emit      (seq_emit),
        .rsp       (seq_rsp),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    // The list contents live here; the read data are registered and come back in the cycle after the address.
    pal_ram #(
        .WIDTH (PAL_DATA_W),
        .DEPTH (CAPACITY)
    ) u_entries (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // The result beat is registered so that done and rsp come straight from
    // flip-flops. The strobe is control state and is reset; the payload is not.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= seq_emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (seq_emit)
        begin
            rsp_reg <= seq_rsp;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

`default_nettype wire

// ----- tb/tb_positional_array_list_unit.sv -----
`timescale 1ns / 1ps

// Self-checking bench for the positional array list.
// Request beats are queued up front by the stimulus block and presented by a
// clocked driver in random bursts. A clocked monitor checks every result beat
// against a predictor that keeps its own copy of the list.
module tb_positional_array_list_unit;
    import pal_pkg::*;

    // Longest requests are an insert at the head of a list one short of full
    // and a delete at the head of a full list.
    localparam int unsigned DRAIN_CYCLES  = 2 * PAL_CAPACITY + 8;
    localparam int unsigned RANDOM_ITEMS  = 2000;
    localparam int unsigned REPORT_LIMIT  = 10;

    typedef struct {
        pal_func_t func;
        pal_out_t  rsp;
    } list_expect_t;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     start = 1'b0;
    pal_in_t  req = '0;
    logic     busy;
    logic     done;
    pal_out_t rsp;

    positional_array_list_unit uut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .req   (req),
        .busy  (busy),
        .done  (done),
        .rsp   (rsp)
    );

    // Request beats waiting to be presented, and the results that the
    // accepted ones are owed, oldest first.
    pal_in_t      pending_req[$];
    list_expect_t expected_rsp[$];

    // Predictor state: the list contents and its length as the block should
    // hold them after every accepted request.
    logic [PAL_DATA_W-1:0] list_words [PAL_CAPACITY];
    int unsigned           list_len = 0;

    // Length the stimulus generator believes the list will have; used only to
    // steer positions towards valid ones.
    int unsigned stim_len = 0;

    int unsigned mismatch_count = 0;
    int unsigned func_seen [4];
    int unsigned status_seen [4];
    int unsigned deepest = 0;

    // Sender pacing: a burst of presented beats, then a gap with start low.
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Generous ceiling: several times the slowest correct run.
    initial
    begin
        #12_000_000;
        $display("status: fail");
        $finish;
    end

    // Applies one request to the predictor's list and returns the result
    // the block must give for it. A refused request changes nothing.
    function automatic pal_out_t apply_list_request(input pal_in_t r);
        pal_out_t    o;
        int unsigned p;
        int unsigned i;
        p = r.pos;
        o.data_out = '0;
        o.status = PAL_ST_OK;
        case (r.func)
            PAL_FN_INSERT:
            begin
                // Fullness is judged before the position.
                if (list_len >= PAL_CAPACITY)
                    o.status = PAL_ST_FULL;
                else if (p > list_len)
                    o.status = PAL_ST_BADPOS;
                else
                begin
                    for (i = list_len; i > p; i--)
                        list_words[i] = list_words[i - 1];
                    list_words[p] = r.value;
                    list_len++;
                end
            end
            PAL_FN_APPEND:
            begin
                if (list_len >= PAL_CAPACITY)
                    o.status = PAL_ST_FULL;
                else
                begin
                    list_words[list_len] = r.value;
                    list_len++;
                end
            end
            PAL_FN_DELETE:
            begin
                if (list_len == 0)
                    o.status = PAL_ST_EMPTY;
                else if (p >= list_len)
                    o.status = PAL_ST_BADPOS;
                else
                begin
                    o.data_out = list_words[p];
                    for (i = p; i + 1 < list_len; i++)
                        list_words[i] = list_words[i + 1];
                    list_len--;
                end
            end
            default:
            begin
                if (list_len == 0)
                    o.status = PAL_ST_EMPTY;
                else if (p >= list_len)
                    o.status = PAL_ST_BADPOS;
                else
                    o.data_out = list_words[p];
            end
        endcase
        o.count_out = PAL_CNT_W'(list_len);
        return o;
    endfunction

    // Words are half random, with the extremes and the all-zero and
    // all-one patterns making up the other half.
    function automatic logic [PAL_DATA_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return '0;
            3: return '1;
            default: return $urandom();
        endcase
    endfunction

    // Queues one request beat and tracks the length the list should reach.
    task automatic add_item(input pal_func_t f, input int unsigned p,
                            input logic [PAL_DATA_W-1:0] v);
        pal_in_t r;
        r.func = f;
        r.pos = PAL_POS_W'(p);
        r.value = v;
        pending_req.push_back(r);
        case (f)
            PAL_FN_INSERT: if (stim_len < PAL_CAPACITY && p <= stim_len) stim_len++;
            PAL_FN_APPEND: if (stim_len < PAL_CAPACITY) stim_len++;
            PAL_FN_DELETE: if (stim_len > 0 && p < stim_len) stim_len--;
            default: ;
        endcase
    endtask

    // One random request. grow_pct sets how often it adds an entry rather than
    // deleting or reading one; positions are nearly always valid, and a small
    // share of the beats are pure noise with any operation and any position.
    task automatic add_shaped(input int unsigned grow_pct);
        pal_func_t   f;
        int unsigned p;
        if ($urandom_range(0, 99) < 8)
        begin
            f = pal_func_t'($urandom_range(0, 3));
            p = $urandom_range(0, 255);
        end
        else if ($urandom_range(0, 99) < grow_pct)
        begin
            f = $urandom_range(0, 1) ? PAL_FN_APPEND : PAL_FN_INSERT;
            // Append ignores the position, so it carries any pattern there.
            p = (f == PAL_FN_APPEND) ? $urandom_range(0, 255) : $urandom_range(0, stim_len);
        end
        else
        begin
            f = $urandom_range(0, 1) ? PAL_FN_DELETE : PAL_FN_READ;
            p = (stim_len == 0) ? 0 : $urandom_range(0, stim_len - 1);
        end
        add_item(f, p, pick_word());
    endtask

    // Fills the list to capacity, knocks on it while full, then empties it
    // and knocks on it while empty.
    task automatic fill_and_drain();
        while (stim_len < PAL_CAPACITY)
            add_shaped(100);
        repeat ($urandom_range(4, 8))
            add_shaped(100);
        // An insert that is both too far out and on a full list must report
        // full, as fullness is checked first.
        add_item(PAL_FN_INSERT, $urandom_range(PAL_CAPACITY + 1, 255), pick_word());
        add_item(PAL_FN_READ, PAL_CAPACITY - 1, '0);
        while (stim_len > 0)
            add_shaped(0);
        repeat ($urandom_range(2, 5))
            add_shaped(0);
    endtask

    // Driver. A beat is taken at an edge where start is high and busy low;
    // the prediction is made at that very edge. While the block is busy the
    // presented beat is held, otherwise the next one goes out unless the
    // sender is sitting in a gap between bursts.
    always @(posedge clk or negedge rst_n)
    begin : driver
        logic         taken;
        logic         next_start;
        pal_in_t      next_req;
        list_expect_t e;
        if (!rst_n)
        begin
            start <= 1'b0;
            req <= '0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            taken = start && !busy;
            next_start = start;
            next_req = req;
            if (taken)
            begin
                e.func = req.func;
                e.rsp = apply_list_request(req);
                expected_rsp.push_back(e);
                void'(pending_req.pop_front());
            end
            if (!start || taken)
            begin
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 16);
                    // Now and then a long stretch with no idling at all.
                    if ($urandom_range(0, 9) == 0)
                        burst_left = $urandom_range(30, 80);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
                if (gap_left > 0)
                begin
                    gap_left--;
                    next_start = 1'b0;
                end
                else if (pending_req.size() > 0)
                begin
                    next_start = 1'b1;
                    next_req = pending_req[0];
                    burst_left--;
                end
                else
                    next_start = 1'b0;
            end
            start <= next_start;
            req <= next_req;
        end
    end

    // Monitor. done marks a result beat for exactly one cycle and the beat is
    // taken at the edge that closes that cycle, so it is sampled here.
    always @(posedge clk)
    begin : monitor
        list_expect_t e;
        if (rst_n && done)
        begin
            if (expected_rsp.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected result beat: data %0d count %0d status %s",
                             rsp.data_out, rsp.count_out, rsp.status.name());
            end
            else
            begin
                e = expected_rsp.pop_front();
                func_seen[e.func]++;
                status_seen[e.rsp.status]++;
                if (e.rsp.count_out > deepest)
                    deepest = e.rsp.count_out;
                if (rsp.data_out !== e.rsp.data_out || rsp.count_out !== e.rsp.count_out
                    || rsp.status !== e.rsp.status)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("%s mismatch: expected %0d/%0d/%s, got %0d/%0d/%s",
                                 e.func.name(), e.rsp.data_out, e.rsp.count_out,
                                 e.rsp.status.name(), rsp.data_out, rsp.count_out,
                                 rsp.status.name());
                end
            end
        end
    end

    initial
    begin : stimulus
        int unsigned directed_count;
        // Directed opening: the empty list, the empty and bad-position refusals,
        // inserts at the head, in the middle and at the very end, deletes at both
        // ends, and the extreme words and positions.
        add_item(PAL_FN_READ,   0,   '0);
        add_item(PAL_FN_DELETE, 0,   '0);
        add_item(PAL_FN_INSERT, 1,   32'h1234_5678);
        add_item(PAL_FN_INSERT, 0,   32'h8000_0000);
        add_item(PAL_FN_APPEND, 255, 32'h7fff_ffff);
        add_item(PAL_FN_INSERT, 2,   32'hffff_ffff);
        add_item(PAL_FN_INSERT, 1,   32'h0000_0000);
        add_item(PAL_FN_INSERT, 255, 32'h0000_0001);
        add_item(PAL_FN_READ,   3,   '1);
        add_item(PAL_FN_READ,   4,   '0);
        add_item(PAL_FN_READ,   128, '0);
        add_item(PAL_FN_DELETE, 4,   '0);
        add_item(PAL_FN_DELETE, 0,   '0);
        add_item(PAL_FN_DELETE, 2,   '0);
        add_item(PAL_FN_DELETE, 1,   '0);
        add_item(PAL_FN_READ,   0,   '0);
        add_item(PAL_FN_DELETE, 0,   '0);
        add_item(PAL_FN_APPEND, 0,   32'h5555_5555);
        add_item(PAL_FN_APPEND, 170, 32'haaaa_aaaa);
        add_item(PAL_FN_READ,   255, '0);
        directed_count = pending_req.size();

        // Random part: one full fill and drain first, then phases that lean
        // towards growing, shrinking or churning the list.
        fill_and_drain();
        while (pending_req.size() < directed_count + RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 6))
                0:       fill_and_drain();
                1, 2:    repeat ($urandom_range(10, 60)) add_shaped(75);
                3, 4:    repeat ($urandom_range(10, 60)) add_shaped(25);
                default: repeat ($urandom_range(10, 60)) add_shaped(50);
            endcase
        end

        @(posedge rst_n);
        while (pending_req.size() != 0 || start || expected_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d insert, %0d append, %0d delete and %0d read requests.",
                 func_seen[PAL_FN_INSERT], func_seen[PAL_FN_APPEND],
                 func_seen[PAL_FN_DELETE], func_seen[PAL_FN_READ]);
        $display("Outcomes: %0d ok, %0d full, %0d bad position, %0d empty; longest list %0d.",
                 status_seen[PAL_ST_OK], status_seen[PAL_ST_FULL],
                 status_seen[PAL_ST_BADPOS], status_seen[PAL_ST_EMPTY], deepest);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- sim.f -----
src/pal_pkg.sv
src/pal_ram.sv
src/pal_seq.sv
src/positional_array_list_unit.sv
tb/tb_positional_array_list_unit.sv
